>>> rtl/core/feathered_rect_mask_pixel_top_assert.svh
// ----------------------------------------------------------------------------
// feathered rectangle mask: assertion macros
// shared property forms for the port checker, clocked on clk
// ----------------------------------------------------------------------------
`ifndef FEATHERED_RECT_MASK_PIXEL_TOP_ASSERT_SVH
`define FEATHERED_RECT_MASK_PIXEL_TOP_ASSERT_SVH

// same-cycle implication, off while rst is high
`define FRMASK_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frmask port check failed");

// next-cycle implication, off while rst is high
`define FRMASK_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frmask port check failed");

// same-cycle implication that also holds around reset
`define FRMASK_AST_RAW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("frmask port check failed");

`endif

>>> rtl/core/frmask_pkg.sv
// ----------------------------------------------------------------------------
// frmask_pkg
// shared widths, register indexes and reset values of the feathered mask
// ----------------------------------------------------------------------------
`default_nettype none

package frmask_pkg;

  localparam int MAX_FRAME_DIM_DEF = 1024;

  localparam int PIX_W      = 10;
  localparam int DIM_REG_W  = 11;
  localparam int FRAC_W     = 18;
  localparam int FEATHER_W  = 16;
  localparam int WEIGHT_W   = 17;
  localparam int FRAC_SHIFT = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 24;

  localparam logic [WEIGHT_W-1:0] Q16_ONE = 17'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_WEIGHT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FEATHER      = 4'd7;

  // reset values
  localparam logic [DIM_REG_W-1:0] RST_FRAME_DIM   = 11'd64;
  localparam logic [FRAC_W-1:0]    RST_RECT_POS    = 18'd0;
  localparam logic [FRAC_W-1:0]    RST_RECT_SIZE   = 18'h10000;
  localparam logic [WEIGHT_W-1:0]  RST_FILL_WEIGHT = 17'h10000;
  localparam logic [FEATHER_W-1:0] RST_FEATHER     = 16'd0;

endpackage

`default_nettype wire

>>> rtl/core/frmask_div.sv
// ----------------------------------------------------------------------------
// frmask_div
// pipelined restoring divider, one quotient bit per stage, valid/ready flow
// ----------------------------------------------------------------------------
`default_nettype none

module frmask_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 23,
  parameter int Q_W   = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [DEN_W-1:0] in_den,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [Q_W-1:0]        out_quo
);

  // stage 0 holds the operands, stage k resolves quotient bit Q_W-k
  logic [Q_W:0]   vld;
  logic [Q_W+1:0] rdy;

  logic [NUM_W-1:0] rem [0:Q_W-1];
  logic [DEN_W-1:0] dd  [0:Q_W-1];
  logic [Q_W-1:0]   qq  [1:Q_W];

  assign rdy[Q_W+1] = out_ready;

  genvar g;
  for (g = 0; g <= Q_W; g++) begin : g_rdy
    assign rdy[g] = ~vld[g] | rdy[g+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int i = 1; i <= Q_W; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0] <= in_num;
      dd[0]  <= in_den;
    end
  end

  for (g = 1; g <= Q_W; g++) begin : g_step
    localparam int B = Q_W - g;
    logic [NUM_W-1:0] trial;
    logic             take;
    logic [Q_W-1:0]   q_prev;
    logic [Q_W-1:0]   q_bit;

    assign trial = NUM_W'(dd[g-1]) << B;
    assign take  = rem[g-1] >= trial;
    assign q_bit = take ? (Q_W'(1) << B) : '0;

    if (g == 1) begin : g_first
      assign q_prev = '0;
    end else begin : g_rest
      assign q_prev = qq[g-1];
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) qq[g] <= q_prev | q_bit;
    end

    if (g < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (rdy[g]) begin
          rem[g] <= take ? (rem[g-1] - trial) : rem[g-1];
          dd[g]  <= dd[g-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[Q_W];
  assign out_quo   = qq[Q_W];

endmodule

`default_nettype wire

>>> rtl/core/feathered_rect_mask_pixel_top.sv
// ----------------------------------------------------------------------------
// feathered_rect_mask_pixel_top
// Q16 mask weight of one feathered rectangle for each pixel coordinate
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per transaction: pixel_col and pixel_row.
//   m_axis returns one transaction per pixel with the Q16 mask_value, in the
//   order the pixels came in.
//   The cfg channel writes the eight registers (index 0..7); cfg_ready is
//   always high and writes to other indexes are dropped. Write only while
//   no pixel is in flight.
//   Five stages convert the rectangle to pixels, find the ramps and form
//   the numerator, then an 18-stage divider does the rounding division,
//   one quotient bit per stage.
//   Throughput is one pixel per cycle, any gaps, while m_axis_tready is high.
//   When m_axis_tready is low every stage with a valid pixel holds and empty
//   stages keep filling; s_axis_tready drops only when the whole pipe is full.
//   Reset loads the register defaults (64x64 frame, full-frame rectangle,
//   weight one, no feather) and empties the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module feathered_rect_mask_pixel_top #(
  parameter int MAX_FRAME_DIM = frmask_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [9:0] pixel_col, [19:10] pixel_row, [23:20] zero
  input  wire logic [frmask_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [16:0] mask_value, [23:17] zero
  output logic [frmask_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [frmask_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frmask_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PIX_W  = frmask_pkg::PIX_W;
  localparam int FRAC_W = frmask_pkg::FRAC_W;
  localparam int FTH_W  = frmask_pkg::FEATHER_W;
  localparam int WT_W   = frmask_pkg::WEIGHT_W;
  localparam int SH     = frmask_pkg::FRAC_SHIFT;
  localparam int DREG_W = frmask_pkg::DIM_REG_W;

  localparam int DIM_W  = $clog2(MAX_FRAME_DIM + 1);
  localparam int PW     = FRAC_W + DIM_W + 1;
  localparam int UPW    = FRAC_W + DIM_W;
  localparam int FPW    = FTH_W + DIM_W;
  localparam int CRD_W  = (DIM_W + 4 > PIX_W + 2) ? DIM_W + 4 : PIX_W + 2;
  localparam int HV_W   = 2 * DIM_W;
  localparam int NUM_W  = WT_W + HV_W;
  localparam int DIVN_W = NUM_W + 2;
  localparam int DIVD_W = HV_W + 1;
  localparam int NPRE   = 5;

  // configuration registers
  logic [DREG_W-1:0]        frame_width;
  logic [DREG_W-1:0]        frame_height;
  logic signed [FRAC_W-1:0] rect_left_frac;
  logic signed [FRAC_W-1:0] rect_top_frac;
  logic [FRAC_W-1:0]        rect_width_frac;
  logic [FRAC_W-1:0]        rect_height_frac;
  logic [WT_W-1:0]          fill_weight;
  logic [FTH_W-1:0]         feather_frac;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= frmask_pkg::RST_FRAME_DIM;
      frame_height     <= frmask_pkg::RST_FRAME_DIM;
      rect_left_frac   <= frmask_pkg::RST_RECT_POS;
      rect_top_frac    <= frmask_pkg::RST_RECT_POS;
      rect_width_frac  <= frmask_pkg::RST_RECT_SIZE;
      rect_height_frac <= frmask_pkg::RST_RECT_SIZE;
      fill_weight      <= frmask_pkg::RST_FILL_WEIGHT;
      feather_frac     <= frmask_pkg::RST_FEATHER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        frmask_pkg::REG_FRAME_WIDTH:  frame_width      <= cfg_data[DREG_W-1:0];
        frmask_pkg::REG_FRAME_HEIGHT: frame_height     <= cfg_data[DREG_W-1:0];
        frmask_pkg::REG_RECT_LEFT:    rect_left_frac   <= cfg_data[FRAC_W-1:0];
        frmask_pkg::REG_RECT_TOP:     rect_top_frac    <= cfg_data[FRAC_W-1:0];
        frmask_pkg::REG_RECT_WIDTH:   rect_width_frac  <= cfg_data[FRAC_W-1:0];
        frmask_pkg::REG_RECT_HEIGHT:  rect_height_frac <= cfg_data[FRAC_W-1:0];
        frmask_pkg::REG_FILL_WEIGHT:  fill_weight      <= cfg_data[WT_W-1:0];
        frmask_pkg::REG_FEATHER:      feather_frac     <= cfg_data[FTH_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control, front stages
  logic [NPRE-1:0] pv;
  logic [NPRE:0]   prdy;
  logic            div_in_ready;

  assign prdy[NPRE] = div_in_ready;

  genvar g;
  for (g = 0; g < NPRE; g++) begin : g_rdy
    assign prdy[g] = ~pv[g] | prdy[g+1];
  end

  assign s_axis_tready = prdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      if (prdy[0]) pv[0] <= s_axis_tvalid;
      for (int i = 1; i < NPRE; i++) begin
        if (prdy[i]) pv[i] <= pv[i-1];
      end
    end
  end

  // stage 1: clamp the frame, scale fractions by the frame dimension
  logic [DIM_W-1:0]     fw_clamp, fh_clamp;
  logic signed [PW-1:0] fw_ext, fh_ext;
  logic [WT_W-1:0]      wt_sat;

  assign fw_clamp = (32'(frame_width) > 32'(MAX_FRAME_DIM)) ?
                    DIM_W'(MAX_FRAME_DIM) : DIM_W'(frame_width);
  assign fh_clamp = (32'(frame_height) > 32'(MAX_FRAME_DIM)) ?
                    DIM_W'(MAX_FRAME_DIM) : DIM_W'(frame_height);
  assign fw_ext   = $signed(PW'(fw_clamp));
  assign fh_ext   = $signed(PW'(fh_clamp));
  assign wt_sat   = (fill_weight > frmask_pkg::Q16_ONE) ? frmask_pkg::Q16_ONE : fill_weight;

  logic [PIX_W-1:0]     s1_col, s1_row;
  logic signed [PW-1:0] s1_pl, s1_pt;
  logic [UPW-1:0]       s1_pw, s1_ph;
  logic [FPW-1:0]       s1_pfx, s1_pfy;
  logic [DIM_W-1:0]     s1_fw, s1_fh;
  logic [WT_W-1:0]      s1_wt;
  logic                 s1_fnz;

  always_ff @(posedge clk) begin
    if (prdy[0]) begin
      s1_col <= s_axis_tdata[PIX_W-1:0];
      s1_row <= s_axis_tdata[2*PIX_W-1:PIX_W];
      s1_pl  <= PW'(rect_left_frac) * fw_ext;
      s1_pt  <= PW'(rect_top_frac) * fh_ext;
      s1_pw  <= UPW'(rect_width_frac) * UPW'(fw_clamp);
      s1_ph  <= UPW'(rect_height_frac) * UPW'(fh_clamp);
      s1_pfx <= FPW'(feather_frac) * FPW'(fw_clamp);
      s1_pfy <= FPW'(feather_frac) * FPW'(fh_clamp);
      s1_fw  <= fw_clamp;
      s1_fh  <= fh_clamp;
      s1_wt  <= wt_sat;
      s1_fnz <= feather_frac != '0;
    end
  end

  // stage 2: truncate to pixels, clip low edges and extents
  logic signed [CRD_W-1:0] x_px, y_px, w_raw, h_raw, w_room, h_room;
  logic [DIM_W-1:0]        fx_px, fy_px;

  // a negative edge truncates to zero or below, so it clips straight to zero
  assign x_px   = s1_pl[PW-1] ? '0 : $signed(CRD_W'(s1_pl[PW-1:SH]));
  assign y_px   = s1_pt[PW-1] ? '0 : $signed(CRD_W'(s1_pt[PW-1:SH]));
  assign w_raw  = $signed(CRD_W'(s1_pw[UPW-1:SH]));
  assign h_raw  = $signed(CRD_W'(s1_ph[UPW-1:SH]));
  assign w_room = $signed(CRD_W'(s1_fw)) - x_px;
  assign h_room = $signed(CRD_W'(s1_fh)) - y_px;
  assign fx_px  = s1_pfx[FPW-1:SH];
  assign fy_px  = s1_pfy[FPW-1:SH];

  logic [PIX_W-1:0]        s2_col, s2_row;
  logic signed [CRD_W-1:0] s2_x, s2_y, s2_w, s2_h;
  logic [DIM_W-1:0]        s2_fx, s2_fy;
  logic                    s2_feath;
  logic [WT_W-1:0]         s2_wt;

  always_ff @(posedge clk) begin
    if (prdy[1]) begin
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_x     <= x_px;
      s2_y     <= y_px;
      s2_w     <= (w_raw > w_room) ? w_room : w_raw;
      s2_h     <= (h_raw > h_room) ? h_room : h_raw;
      s2_fx    <= fx_px;
      s2_fy    <= fy_px;
      s2_feath <= s1_fnz && (fx_px != '0) && (fy_px != '0);
      s2_wt    <= s1_wt;
    end
  end

  // stage 3: inside test and ramp factors, {num, den} per axis
  function automatic logic [2*DIM_W-1:0] axis_fac(
    input logic signed [CRD_W-1:0] pos,
    input logic signed [CRD_W-1:0] start,
    input logic signed [CRD_W-1:0] len,
    input logic [DIM_W-1:0]        n,
    input logic                    act
  );
    logic signed [CRD_W-1:0] ns;
    logic signed [CRD_W-1:0] off_lo;
    logic signed [CRD_W-1:0] off_hi;
    logic [DIM_W-1:0]        num;
    logic [DIM_W-1:0]        den;
    ns     = $signed(CRD_W'(n));
    off_lo = pos - start;
    off_hi = pos - (start + len - ns);
    num    = DIM_W'(1);
    den    = DIM_W'(1);
    if (act && (len > ns + ns)) begin
      if (off_lo < ns) begin
        // rising ramp; a one-pixel feather gives zero
        if (n > DIM_W'(1)) begin
          num = DIM_W'(off_lo);
          den = n - DIM_W'(1);
        end else begin
          num = '0;
        end
      end else if (off_hi >= 0) begin
        // falling ramp; a one-pixel feather gives one
        if (n > DIM_W'(1)) begin
          num = DIM_W'(ns - 1 - off_hi);
          den = n - DIM_W'(1);
        end
      end
    end
    return {num, den};
  endfunction

  logic signed [CRD_W-1:0] col_s, row_s;
  logic                    in_rect;
  logic [2*DIM_W-1:0]      hfac, vfac;

  assign col_s   = $signed(CRD_W'(s2_col));
  assign row_s   = $signed(CRD_W'(s2_row));
  assign in_rect = (s2_w > 0) && (s2_h > 0) &&
                   (col_s >= s2_x) && (col_s < s2_x + s2_w) &&
                   (row_s >= s2_y) && (row_s < s2_y + s2_h);
  assign hfac    = axis_fac(col_s, s2_x, s2_w, s2_fx, s2_feath);
  assign vfac    = axis_fac(row_s, s2_y, s2_h, s2_fy, s2_feath);

  logic             s3_in;
  logic [DIM_W-1:0] s3_hn, s3_hd, s3_vn, s3_vd;
  logic [WT_W-1:0]  s3_wt;

  always_ff @(posedge clk) begin
    if (prdy[2]) begin
      s3_in <= in_rect;
      s3_hn <= hfac[2*DIM_W-1:DIM_W];
      s3_hd <= hfac[DIM_W-1:0];
      s3_vn <= vfac[2*DIM_W-1:DIM_W];
      s3_vd <= vfac[DIM_W-1:0];
      s3_wt <= s2_wt;
    end
  end

  // stage 4: corner products; outside pixels become 0/1
  logic [HV_W-1:0] s4_hv, s4_den;
  logic [WT_W-1:0] s4_wt;

  always_ff @(posedge clk) begin
    if (prdy[3]) begin
      s4_hv  <= s3_in ? HV_W'(s3_hn) * HV_W'(s3_vn) : '0;
      s4_den <= s3_in ? HV_W'(s3_hd) * HV_W'(s3_vd) : HV_W'(1);
      s4_wt  <= s3_wt;
    end
  end

  // stage 5: weighted numerator
  logic [NUM_W-1:0] s5_num;
  logic [HV_W-1:0]  s5_den;

  always_ff @(posedge clk) begin
    if (prdy[4]) begin
      s5_num <= NUM_W'(s4_wt) * NUM_W'(s4_hv);
      s5_den <= s4_den;
    end
  end

  // round half up: (2*num + den) / (2*den)
  logic [DIVN_W-1:0] div_num;
  logic [DIVD_W-1:0] div_den;
  logic [WT_W-1:0]   div_quo;

  assign div_num = DIVN_W'({s5_num, 1'b0}) + DIVN_W'(s5_den);
  assign div_den = {s5_den, 1'b0};

  frmask_div #(
    .NUM_W (DIVN_W),
    .DEN_W (DIVD_W),
    .Q_W   (WT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pv[NPRE-1]),
    .in_ready  (div_in_ready),
    .in_num    (div_num),
    .in_den    (div_den),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_quo   (div_quo)
  );

  assign m_axis_tdata = frmask_pkg::M_TDATA_W'(div_quo);

endmodule

`default_nettype wire

>>> rtl/core/frmask_chk.sv
// ----------------------------------------------------------------------------
// frmask_chk
// port-level checks of the feathered mask block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "feathered_rect_mask_pixel_top_assert.svh"

module frmask_chk (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [frmask_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                             cfg_ready
);

  logic mask_ok;

  assign mask_ok = (m_axis_tdata[frmask_pkg::WEIGHT_W-1:0] <= frmask_pkg::Q16_ONE) &&
                   (m_axis_tdata[frmask_pkg::M_TDATA_W-1:frmask_pkg::WEIGHT_W] == '0);

  // a stalled result stays offered and unchanged
  `FRMASK_AST_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `FRMASK_AST_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // mask never exceeds one and the pad bits stay clear
  `FRMASK_AST_IMP(a_mask_range, m_axis_tvalid, mask_ok)

  // reset empties the pipe and leaves both input sides open
  `FRMASK_AST_RAW(a_reset_empty, $past(rst), !m_axis_tvalid && s_axis_tready && cfg_ready)

endmodule

bind feathered_rect_mask_pixel_top frmask_chk u_frmask_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);

`default_nettype wire

>>> dv/frmask_checker.sv
// ----------------------------------------------------------------------------
// frmask_checker
// watches the pixel, mask and register channels of the feathered rectangle
// mask, predicts the Q16 mask of every accepted pixel and compares it, in
// order, with the returned mask transactions
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frmask_checker #(
  parameter int MAX_DIM = frmask_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  input  wire logic                              s_axis_tready,
  input  wire logic [frmask_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic [frmask_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [frmask_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [frmask_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                     fail_count,
  output int                                     pending_masks
);
  import frmask_pkg::*;

  localparam longint Q16_DEN = longint'(1) << FRAC_SHIFT;

  logic [DIM_REG_W-1:0] frame_w, frame_h;
  logic [FRAC_W-1:0]    rect_left, rect_top, rect_wid, rect_hgt;
  logic [WEIGHT_W-1:0]  fill_wt;
  logic [FEATHER_W-1:0] feather;

  logic [WEIGHT_W-1:0] expected_masks[$];
  int errs = 0;

  // fraction of a frame dimension to whole pixels, truncated toward zero
  function automatic longint to_px(input longint frac, input longint dim);
    return (frac * dim) / Q16_DEN;
  endfunction

  // linear ramp along one axis as num/den, 1/1 away from the borders
  function automatic void ramp_factor(input longint pos, input longint start,
                                      input longint len, input longint n,
                                      input bit on,
                                      output longint unsigned num,
                                      output longint unsigned den);
    num = 1;
    den = 1;
    if (!on || len <= 2 * n) return;
    if (pos < start + n) begin
      if (n > 1) begin
        num = pos - start;
        den = n - 1;
      end else begin
        num = 0;
      end
    end else if (pos >= start + len - n) begin
      if (n > 1) begin
        num = n - 1 - (pos - (start + len - n));
        den = n - 1;
      end
    end
  endfunction

  function automatic logic [WEIGHT_W-1:0] mask_at(input logic [PIX_W-1:0] col,
                                                  input logic [PIX_W-1:0] row);
    longint fw, fh, x, y, w, h, fx, fy, pc, pr;
    longint unsigned wt, hn, hd, vn, vd, num, den;
    bit ramps_on;
    pc = col;
    pr = row;
    fw = (frame_w > MAX_DIM) ? MAX_DIM : frame_w;
    fh = (frame_h > MAX_DIM) ? MAX_DIM : frame_h;
    x = to_px(longint'($signed(rect_left)), fw);
    y = to_px(longint'($signed(rect_top)), fh);
    w = to_px(longint'(rect_wid), fw);
    h = to_px(longint'(rect_hgt), fh);
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    if (w > fw - x) w = fw - x;
    if (h > fh - y) h = fh - y;
    if (w <= 0 || h <= 0) return '0;
    if (pc < x || pc >= x + w || pr < y || pr >= y + h) return '0;
    wt = (fill_wt > Q16_ONE) ? Q16_ONE : fill_wt;
    fx = to_px(longint'(feather), fw);
    fy = to_px(longint'(feather), fh);
    ramps_on = (feather != 0) && (fx > 0) && (fy > 0);
    ramp_factor(pc, x, w, fx, ramps_on, hn, hd);
    ramp_factor(pr, y, h, fy, ramps_on, vn, vd);
    num = wt * hn * vn;
    den = hd * vd;
    // round half up
    return WEIGHT_W'((2 * num + den) / (2 * den));
  endfunction

  always @(posedge clk) begin
    logic [WEIGHT_W-1:0] want;
    if (rst) begin
      frame_w   = RST_FRAME_DIM;
      frame_h   = RST_FRAME_DIM;
      rect_left = RST_RECT_POS;
      rect_top  = RST_RECT_POS;
      rect_wid  = RST_RECT_SIZE;
      rect_hgt  = RST_RECT_SIZE;
      fill_wt   = RST_FILL_WEIGHT;
      feather   = RST_FEATHER;
      expected_masks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w   = cfg_data[DIM_REG_W-1:0];
          REG_FRAME_HEIGHT: frame_h   = cfg_data[DIM_REG_W-1:0];
          REG_RECT_LEFT:    rect_left = cfg_data[FRAC_W-1:0];
          REG_RECT_TOP:     rect_top  = cfg_data[FRAC_W-1:0];
          REG_RECT_WIDTH:   rect_wid  = cfg_data[FRAC_W-1:0];
          REG_RECT_HEIGHT:  rect_hgt  = cfg_data[FRAC_W-1:0];
          REG_FILL_WEIGHT:  fill_wt   = cfg_data[WEIGHT_W-1:0];
          REG_FEATHER:      feather   = cfg_data[FEATHER_W-1:0];
          default: ;
        endcase
      end
      // retire before queueing so an empty store is caught
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_masks.size() == 0) begin
          errs++;
          $display("%0t: mask transaction with none expected: expected none, actual %0d",
                   $time, m_axis_tdata[WEIGHT_W-1:0]);
        end else begin
          want = expected_masks.pop_front();
          if (m_axis_tdata[WEIGHT_W-1:0] !== want) begin
            errs++;
            $display("%0t: mask_value mismatch: expected %0d, actual %0d",
                     $time, want, m_axis_tdata[WEIGHT_W-1:0]);
          end
          if (m_axis_tdata[M_TDATA_W-1:WEIGHT_W] !== '0) begin
            errs++;
            $display("%0t: tdata padding mismatch: expected 0, actual %0h",
                     $time, m_axis_tdata[M_TDATA_W-1:WEIGHT_W]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_masks.insert(expected_masks.size(),
                              mask_at(s_axis_tdata[PIX_W-1:0],
                                      s_axis_tdata[2*PIX_W-1:PIX_W]));
    end
    fail_count    <= errs;
    pending_masks <= expected_masks.size();
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives pixel coordinates and register settings into the feathered rectangle
// mask under several sender and receiver idle patterns; the checker instance
// predicts every mask and reports the failure count for the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import frmask_pkg::*;

  localparam int IDLE_LIMIT       = 2000;
  localparam int DRAIN_CYCLES     = 30;
  localparam int LONG_HOLD        = 100;
  localparam int PHASES           = 12;
  localparam int PIXELS_PER_PHASE = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_masks;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int frame_w_now = RST_FRAME_DIM;
  int frame_h_now = RST_FRAME_DIM;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  feathered_rect_mask_pixel_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  frmask_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_masks (pending_masks)
  );

  // mask receiver, with one long hold-off so the pipe fills and backs up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // wait until the last accepted pixel is counted, then for the store to empty
  task automatic drain();
    do @(posedge clk); while (pending_masks != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setup(input int fw, input int fh, input int left, input int top,
                            input int wid, input int hgt, input int wt, input int fth,
                            input bit stray);
    s_axis_tvalid <= 1'b0;
    drain();
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_RECT_LEFT, left);
    write_reg(REG_RECT_TOP, top);
    write_reg(REG_RECT_WIDTH, wid);
    write_reg(REG_RECT_HEIGHT, hgt);
    write_reg(REG_FILL_WEIGHT, wt);
    write_reg(REG_FEATHER, fth);
    // index past the register list, must be dropped
    if (stray)
      write_reg(CFG_IDX_W'($urandom_range(REG_FEATHER + 1, (1 << CFG_IDX_W) - 1)), $urandom);
    cfg_valid <= 1'b0;
    frame_w_now = fw;
    frame_h_now = fh;
  endtask

  task automatic send_pixel(input int col, input int row);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({PIX_W'(row), PIX_W'(col)});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic int pick_dim();
    case ($urandom_range(19))
      0:       return 0;
      1:       return 1;
      2:       return MAX_FRAME_DIM_DEF;
      3:       return $urandom_range(MAX_FRAME_DIM_DEF + 1, (1 << DIM_REG_W) - 1);
      4, 5:    return $urandom_range(200, MAX_FRAME_DIM_DEF);
      default: return $urandom_range(2, 120);
    endcase
  endfunction

  function automatic int pick_pos();
    case ($urandom_range(9))
      0:       return -65536;
      1:       return 65536;
      2:       return $urandom_range(0, (1 << FRAC_W) - 1);
      3:       return -int'($urandom_range(1, 30000));
      default: return $urandom_range(0, 40000);
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 131072;
      2:       return $urandom_range(0, (1 << FRAC_W) - 1);
      default: return $urandom_range(16384, 65536);
    endcase
  endfunction

  // mostly inside the frame so the rectangle and its ramps get hit
  function automatic int pick_coord(input int dim);
    int lim;
    lim = (dim > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : dim;
    if (lim > 0 && $urandom_range(3) != 0) return $urandom_range(0, lim - 1);
    return $urandom_range(0, (1 << PIX_W) - 1);
  endfunction

  task automatic random_setup();
    int wt, fth;
    case ($urandom_range(5))
      0:       wt = Q16_ONE;
      1:       wt = $urandom_range(0, (1 << WEIGHT_W) - 1);
      default: wt = $urandom_range(0, Q16_ONE);
    endcase
    case ($urandom_range(7))
      0:       fth = 0;
      1:       fth = $urandom_range(0, (1 << FEATHER_W) - 1);
      2:       fth = 32768;
      default: fth = $urandom_range(1, 12000);
    endcase
    load_setup(pick_dim(), pick_dim(), pick_pos(), pick_pos(), pick_size(), pick_size(),
               wt, fth, $urandom_range(3) == 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset setup: full 64x64 frame, corners and pixels outside the frame
    send_pixel(0, 0);
    send_pixel(63, 63);
    send_pixel(64, 0);
    send_pixel(0, 64);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    send_pixel(0, 1023);
    send_pixel(32, 17);

    // 32x32 rectangle at (16,16) with a four pixel feather
    load_setup(64, 64, 16384, 16384, 32768, 32768, Q16_ONE, 4096, 1'b0);
    send_pixel(16, 16);
    send_pixel(17, 18);
    send_pixel(19, 30);
    send_pixel(45, 46);
    send_pixel(47, 47);
    send_pixel(48, 30);
    send_pixel(15, 30);
    send_pixel(30, 30);

    // one pixel feather: rising edge gives zero, falling edge full weight
    load_setup(64, 64, 16384, 16384, 32768, 32768, 40000, 1024, 1'b1);
    send_pixel(16, 30);
    send_pixel(47, 30);
    send_pixel(30, 30);

    // oversized frame, weight above one, rectangle hanging off the low edges
    load_setup((1 << DIM_REG_W) - 1, (1 << DIM_REG_W) - 1, -65536, -65536, 131072, 131072,
               (1 << WEIGHT_W) - 1, 32768, 1'b0);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(512, 700);

    // zero frame width, then an empty rectangle
    load_setup(0, 64, 0, 0, 65536, 65536, Q16_ONE, 0, 1'b0);
    send_pixel(0, 0);
    load_setup(64, 64, 0, 0, 0, 65536, Q16_ONE, 0, 1'b0);
    send_pixel(5, 5);

    for (int ph = 0; ph < PHASES; ph++) begin
      random_setup();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 76; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 76; end
        default: begin tx_idle_pct = 20; rx_stall_pct <= 20; end
      endcase
      if (ph == 4) hold_req <= 1'b1;
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        if (ph % 3 == 2 && n == PIXELS_PER_PHASE / 2) begin
          s_axis_tvalid <= 1'b0;
          drain();
        end
        send_pixel(pick_coord(frame_w_now), pick_coord(frame_h_now));
      end
    end

    s_axis_tvalid <= 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/frmask_pkg.sv
rtl/core/frmask_div.sv
rtl/core/feathered_rect_mask_pixel_top.sv
rtl/core/frmask_chk.sv
dv/frmask_checker.sv
dv/testbench.sv
